// ----- sv/u8d_pkg.sv -----
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared widths, lead byte codes and the result type of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 26;
   localparam int LEN_W  = 3;
   localparam int CONT_W = 6;

   // lead byte thresholds, each one the lowest byte of its class
   localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD5_MIN = 8'hF8;
   localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'hFF;

   localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
   localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
   localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
   localparam logic [LEN_W-1:0] LEN_4    = 3'd4;
   localparam logic [LEN_W-1:0] LEN_5    = 3'd5;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_len;
      logic             bad_lead;
   } u8d_result_type;

endpackage

// ----- sv/u8d_stream_if.sv -----
// ----------------------------------------------------------------------------
// u8d stream interfaces
// Valid/ready channels for the byte input and the decoded result output.
// ----------------------------------------------------------------------------
interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [25:0] code_point;
   logic [2:0]  seq_len;
   logic        bad_lead;

   modport source (output valid, output code_point, output seq_len, output bad_lead,
                   input ready);
   modport sink   (input valid, input code_point, input seq_len, input bad_lead,
                   output ready);
endinterface

// ----- sv/u8d_in_stage.sv -----
// ----------------------------------------------------------------------------
// u8d_in_stage
// Input register for one byte beat, refilled in the cycle it is consumed.
// ----------------------------------------------------------------------------
module u8d_in_stage (
   input  logic                        clock,
   input  logic                        reset,
   u8d_req_if.sink                     req_ch,
   input  logic                        take,
   output logic                        byte_valid,
   output logic [u8d_pkg::BYTE_W-1:0]  byte_data
);
   import u8d_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in_nx;
   logic              beat;

   assign req_ch.ready = !valid_ff || take;
   assign beat         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in   = valid_ff;
      byte_in_nx = byte_ff;
      if (beat) begin
         valid_in   = 1'b1;
         byte_in_nx = req_ch.byte_in;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in_nx;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

// ----- sv/u8d_step.sv -----
// ----------------------------------------------------------------------------
// u8d_step
// Sequence state and the decode of one byte into the next state and result.
// ----------------------------------------------------------------------------
module u8d_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_valid,
   input  logic [u8d_pkg::BYTE_W-1:0]  byte_data,
   input  logic                        res_space,
   output logic                        take,
   output logic                        res_valid,
   output u8d_pkg::u8d_result_type     res
);
   import u8d_pkg::*;

   logic [LEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic [CP_W-1:0]  partial_ff, partial_in;
   logic [LEN_W-1:0] total_len_ff, total_len_in;
   logic             has_res;
   logic [CP_W-1:0]  shifted;

   assign shifted = {partial_ff[CP_W-CONT_W-1:0], byte_data[CONT_W-1:0]};

   always_comb begin
      bytes_left_in  = bytes_left_ff;
      partial_in     = partial_ff;
      total_len_in   = total_len_ff;
      has_res        = 1'b0;
      res.code_point = '0;
      res.seq_len    = LEN_NONE;
      res.bad_lead   = 1'b0;
      if (bytes_left_ff != LEN_NONE) begin
         // inside a sequence every byte counts as a continuation
         partial_in    = shifted;
         bytes_left_in = bytes_left_ff - LEN_1;
         if (bytes_left_ff == LEN_1) begin
            has_res        = 1'b1;
            res.code_point = shifted;
            res.seq_len    = total_len_ff;
            total_len_in   = LEN_NONE;
         end
      end else if (!byte_data[7]) begin
         has_res        = 1'b1;
         res.code_point = {{(CP_W-BYTE_W){1'b0}}, byte_data};
         res.seq_len    = LEN_1;
      end else if (!byte_data[6]) begin
         has_res      = 1'b1;
         res.bad_lead = 1'b1;
      end else begin
         if (byte_data inside {[LEAD5_MIN:BYTE_MAX]}) begin
            total_len_in = LEN_5;
            partial_in   = {{(CP_W-2){1'b0}}, byte_data[1:0]};
         end else if (byte_data inside {[LEAD4_MIN:BYTE_MAX]}) begin
            total_len_in = LEN_4;
            partial_in   = {{(CP_W-3){1'b0}}, byte_data[2:0]};
         end else if (byte_data inside {[LEAD3_MIN:BYTE_MAX]}) begin
            total_len_in = LEN_3;
            partial_in   = {{(CP_W-4){1'b0}}, byte_data[3:0]};
         end else begin
            total_len_in = LEN_2;
            partial_in   = {{(CP_W-5){1'b0}}, byte_data[4:0]};
         end
         bytes_left_in = total_len_in - LEN_1;
      end
   end

   // a byte that finishes nothing moves on even while the result side stalls
   assign take      = byte_valid && (!has_res || res_space);
   assign res_valid = take && has_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= LEN_NONE;
         partial_ff    <= '0;
         total_len_ff  <= LEN_NONE;
      end else if (take) begin
         bytes_left_ff <= bytes_left_in;
         partial_ff    <= partial_in;
         total_len_ff  <= total_len_in;
      end
   end

   a_left_below_total: assert property (@(posedge clock) disable iff (reset)
      bytes_left_ff != LEN_NONE |-> bytes_left_ff < total_len_ff)
      else $error("u8d_step: bytes_left not below sequence length");

   a_lead_opens: assert property (@(posedge clock) disable iff (reset)
      take && bytes_left_ff == LEN_NONE && byte_data[7] && byte_data[6]
      |=> bytes_left_ff != LEN_NONE)
      else $error("u8d_step: lead byte did not open a sequence");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      take && bytes_left_ff == LEN_1
      |=> bytes_left_ff == LEN_NONE && total_len_ff == LEN_NONE)
      else $error("u8d_step: sequence state not cleared after last byte");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      byte_valid && !take |-> has_res && !res_space)
      else $error("u8d_step: byte held without a result stall");

endmodule

// ----- sv/u8d_out_stage.sv -----
// ----------------------------------------------------------------------------
// u8d_out_stage
// Result register that holds a decoded beat until the receiver takes it.
// ----------------------------------------------------------------------------
module u8d_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     res_valid,
   input  u8d_pkg::u8d_result_type  res,
   output logic                     res_space,
   u8d_rsp_if.source                rsp_ch
);
   import u8d_pkg::*;

   logic           valid_ff, valid_in;
   u8d_result_type res_ff, res_in;

   assign res_space = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (res_valid) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.code_point = res_ff.code_point;
   assign rsp_ch.seq_len    = res_ff.seq_len;
   assign rsp_ch.bad_lead   = res_ff.bad_lead;

endmodule

// ----- sv/utf8_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: one byte beat in, one code point beat out per
// completed sequence or stray continuation byte.
// ----------------------------------------------------------------------------
// req_ch carries one raw byte per beat. rsp_ch carries code_point, seq_len
// and bad_lead; a beat appears for every ASCII byte, for the last byte of a
// multi-byte sequence, and for a continuation byte seen as a lead (then
// bad_lead is set and the other fields are zero). Bytes that open or extend
// a sequence give no beat.
// The result of a byte passes through the input register and then the result
// register before it can be taken on rsp_ch.
// Throughput: one byte per cycle, sustained as long as rsp_ch takes its beats.
// When rsp_ch stalls, the result register holds its beat; the next byte that
// would make a result waits in the input register and req_ch.ready drops,
// while bytes that only extend a sequence keep moving.
// Reset (synchronous, active high) empties both registers and drops any open
// sequence.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
   input  logic      clock,
   input  logic      reset,
   u8d_req_if.sink   req_ch,
   u8d_rsp_if.source rsp_ch
);
   import u8d_pkg::*;

   logic              byte_valid;
   logic [BYTE_W-1:0] byte_data;
   logic              take;
   logic              res_valid;
   logic              res_space;
   u8d_result_type    res;

   u8d_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (take),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   u8d_step u_step (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .res_space  (res_space),
      .take       (take),
      .res_valid  (res_valid),
      .res        (res)
   );

   u8d_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_space (res_space),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw UTF-8 bytes into the streaming decoder and checks every code
// point beat against a cycle-free model of the decoder state, with random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import u8d_pkg::*;

   localparam int RESULT_LATENCY = 2;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int NOISE_PCT      = 15;

   logic clock;
   logic reset;

   u8d_req_if req_ch ();
   u8d_rsp_if rsp_ch ();

   utf8_stream_decoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // decoder state as seen by the model
   logic [LEN_W-1:0] seq_remaining;
   logic [CP_W-1:0]  seq_accum;
   logic [LEN_W-1:0] seq_length;

   u8d_result_type pending_points [$];
   int             mismatches;
   int             idle_cycles;
   int             src_idle_pct;
   int             sink_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // returns 1 when the byte closes a sequence or is a lone ascii / stray byte
   function automatic bit decode_byte(input logic [BYTE_W-1:0] b,
                                      output u8d_result_type r);
      r = '0;
      if (seq_remaining != LEN_NONE) begin
         seq_accum     = {seq_accum[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
         seq_remaining = seq_remaining - 1'b1;
         if (seq_remaining != LEN_NONE)
            return 1'b0;
         r.code_point = seq_accum;
         r.seq_len    = seq_length;
         seq_length   = LEN_NONE;
         return 1'b1;
      end
      if (!b[7]) begin
         r.code_point = CP_W'(b);
         r.seq_len    = LEN_1;
         return 1'b1;
      end
      if (b[7:6] != 2'b11) begin
         r.bad_lead = 1'b1;
         return 1'b1;
      end
      if (b >= LEAD5_MIN) begin
         seq_length = LEN_5;
         seq_accum  = CP_W'(b[1:0]);
      end else if (b >= LEAD4_MIN) begin
         seq_length = LEN_4;
         seq_accum  = CP_W'(b[2:0]);
      end else if (b >= LEAD3_MIN) begin
         seq_length = LEN_3;
         seq_accum  = CP_W'(b[3:0]);
      end else begin
         seq_length = LEN_2;
         seq_accum  = CP_W'(b[4:0]);
      end
      seq_remaining = seq_length - 1'b1;
      return 1'b0;
   endfunction

   task automatic report_field(input string field, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // prediction, checking and watchdog share one process so that a byte and
   // a result beat in the same cycle are handled in a fixed order
   always @(posedge clock) begin
      u8d_result_type predicted;
      u8d_result_type want;
      bit             any_beat;
      any_beat = 1'b0;
      if (reset) begin
         seq_remaining = LEN_NONE;
         seq_accum     = '0;
         seq_length    = LEN_NONE;
         idle_cycles   = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            any_beat = 1'b1;
            if (decode_byte(req_ch.byte_in, predicted))
               pending_points.push_back(predicted);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            any_beat = 1'b1;
            if (pending_points.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got cp 0x%0h len %0d bad %0b",
                        $time, rsp_ch.code_point, rsp_ch.seq_len, rsp_ch.bad_lead);
               mismatches++;
            end else begin
               want = pending_points.pop_front();
               report_field("code_point", want.code_point, rsp_ch.code_point);
               report_field("seq_len", want.seq_len, rsp_ch.seq_len);
               report_field("bad_lead", want.bad_lead, rsp_ch.bad_lead);
            end
         end
         idle_cycles = any_beat ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.byte_in <= b;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      while (pending_points.size() != 0)
         @(posedge clock);
      repeat (RESULT_LATENCY + 4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed_sequences;
      logic [BYTE_W-1:0] stream [$];
      stream = '{8'h00, 8'h7F,                     // ascii extremes
                 8'h80, 8'hBF,                     // stray continuation bytes
                 8'hC2, 8'hA9,
                 8'hEF, 8'hBF, 8'hBF,
                 8'hF0, 8'h9F, 8'h98, 8'h80,
                 8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, // five byte, bit 2 of lead dropped
                 8'hC3, 8'hFF,                     // lead-like byte inside a sequence
                 8'hE2, 8'h41, 8'hC0};             // ascii and lead inside a sequence
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      foreach (stream[i])
         send_byte(stream[i]);
      drain();
   endtask

   // mostly well-formed sequences with random payload, some raw noise bytes
   task automatic run_stream(input int n_bytes);
      int               sent;
      logic [LEN_W-1:0] len;
      logic [BYTE_W-1:0] lead;
      sent = 0;
      while (sent < n_bytes) begin
         if ($urandom_range(99) < NOISE_PCT) begin
            send_byte(BYTE_W'($urandom));
            sent++;
         end else begin
            len = LEN_W'($urandom_range(LEN_1, LEN_5));
            case (len)
               LEN_1:   lead = BYTE_W'($urandom_range(0, 127));
               LEN_2:   lead = LEAD2_MIN | BYTE_W'($urandom_range(0, 31));
               LEN_3:   lead = LEAD3_MIN | BYTE_W'($urandom_range(0, 15));
               LEN_4:   lead = LEAD4_MIN | BYTE_W'($urandom_range(0, 7));
               default: lead = LEAD5_MIN | BYTE_W'($urandom_range(0, 7));
            endcase
            send_byte(lead);
            sent++;
            for (int i = 1; i < len; i++) begin
               send_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
               sent++;
            end
         end
      end
      drain();
   endtask

   task automatic test_no_idle;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      run_stream(480);
   endtask

   task automatic test_sender_idle;
      src_idle_pct   = 88;
      sink_stall_pct = 0;
      run_stream(480);
   endtask

   task automatic test_receiver_stall;
      src_idle_pct   = 0;
      sink_stall_pct = 88;
      run_stream(480);
   endtask

   task automatic test_both_idle;
      src_idle_pct   = 16;
      sink_stall_pct = 16;
      run_stream(480);
   endtask

   initial begin
      mismatches     = 0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.byte_in = '0;
      rsp_ch.ready   = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_sequences();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();

      mismatches += pending_points.size();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/u8d_pkg.sv
sv/u8d_stream_if.sv
sv/u8d_in_stage.sv
sv/u8d_step.sv
sv/u8d_out_stage.sv
sv/utf8_stream_decoder.sv
tb/testbench.sv
